@@ rtl/tcce_pkg.sv @@
// Shared types and constants for the text console character engine.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tcce_pkg;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SET   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CH_PRINT,
    CH_LF,
    CH_CR,
    CH_TAB,
    CH_BS
  } char_class_t;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int TAB_ADVANCE = 4;

  localparam logic [15:0] RESET_CELL = 16'h0720;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG      = 2'd0;
  localparam logic [1:0] REG_BG      = 2'd1;
  localparam logic [1:0] REG_BS_MIN  = 2'd2;

  localparam logic [3:0] FG_RESET     = 4'd7;
  localparam logic [3:0] BG_RESET     = 4'd0;
  localparam logic [6:0] BS_MIN_RESET = 7'd14;

  // Saturated positions travel at the widest width the screen can have.
  localparam int OP_COL_W = 7;
  localparam int OP_ROW_W = 6;

  typedef struct packed {
    kind_t                 kind;
    char_class_t           cls;
    logic [7:0]            code;
    logic [OP_COL_W-1:0]   col;
    logic [OP_ROW_W-1:0]   row;
  } op_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [6:0] bs_min;
  } cfg_t;

endpackage

@@ rtl/text_console_character_engine_unit.sv @@
// Text console character engine: a text screen of 16-bit cells with a cursor. After reset
// the screen memory is filled with gray-on-black spaces, one cell per cycle, so the back end
// starts no word until the fill is done, although up to three words are taken and buffered
// in the meantime; configuration writes are taken at all times. For a character, set-cursor
// or read-cell word the back end first updates the cursor and the memory and then loads the
// result register; a wrap to a new line comes first as a step of its own. Clear screen and
// scroll are both paced by the single write port of the screen memory; a wrap followed by a
// line feed on the last row scrolls twice. Up to three words are buffered ahead of the back
// end.
//
// Holds the configuration registers and ties the front end, queue and back end together.
// Depends on tcce_pkg, tcce_front, tcce_queue and tcce_back.
module text_console_character_engine_unit
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [7:0]  col,
  input  logic [7:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_linear,
  output logic [15:0] cell_value,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [3:0] fg;
  logic [3:0] bg;
  logic [6:0] bs_min;
  cfg_t       cfg;

  logic push_valid;
  logic push_ready;
  op_t  push_data;
  logic pop_valid;
  logic pop_en;
  op_t  pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg     <= FG_RESET;
      bg     <= BG_RESET;
      bs_min <= BS_MIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FG:     fg     <= cfg_data[3:0];
        REG_BG:     bg     <= cfg_data[3:0];
        REG_BS_MIN: bs_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.attr   = {bg, fg};
  assign cfg.bs_min = bs_min;

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_data   (pop_data)
  );

  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .op_valid      (pop_valid),
    .op            (pop_data),
    .op_pop        (pop_en),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_linear (cursor_linear),
    .cell_value    (cell_value)
  );

endmodule

@@ rtl/tcce_front.sv @@
// Front end: accepts input words, saturates positions and classifies characters.
// Depends on tcce_pkg; feeds the operation queue.
module tcce_front
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [7:0] col,
  input  logic [7:0] row,
  output logic       push_valid,
  input  logic       push_ready,
  output op_t        push_data
);

  logic valid;
  op_t  op;
  op_t  op_next;

  always_comb begin
    op_next.kind = kind_t'(kind);
    op_next.code = char_code;
    case (char_code)
      CHAR_LF:  op_next.cls = CH_LF;
      CHAR_CR:  op_next.cls = CH_CR;
      CHAR_TAB: op_next.cls = CH_TAB;
      CHAR_BS:  op_next.cls = CH_BS;
      default:  op_next.cls = CH_PRINT;
    endcase
    op_next.col = (col > 8'(COLUMNS - 1)) ? OP_COL_W'(COLUMNS - 1) : col[OP_COL_W-1:0];
    op_next.row = (row > 8'(ROWS - 1)) ? OP_ROW_W'(ROWS - 1) : row[OP_ROW_W-1:0];
  end

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;
  assign push_data  = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (push_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= op_next;
    end
  end

endmodule

@@ rtl/tcce_queue.sv @@
// Two-entry queue of classified operations between the front and back ends.
// Depends on tcce_pkg for the operation type.
module tcce_queue
  import tcce_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_en,
  output op_t  pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/tcce_back.sv @@
// Back end: cursor state, screen memory, scroll/clear sequencer and result register.
// Depends on tcce_pkg; takes operations from the queue head.
module tcce_back
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        op_valid,
  input  op_t         op,
  output logic        op_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_linear,
  output logic [15:0] cell_value
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS + TAB_ADVANCE);
  localparam int RW         = $clog2(ROWS);
  localparam int LW         = $clog2(CELL_COUNT + TAB_ADVANCE);

  typedef enum logic [3:0] {
    ST_FILL   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   col_q;
  logic [CW-1:0]   col_next;
  logic [RW-1:0]   row_q;
  logic [RW-1:0]   row_next;
  logic            resume;
  logic            resume_next;
  logic            res_read;
  logic            res_read_next;
  logic [AW-1:0]   fill_addr;
  logic [AW-1:0]   fill_addr_next;
  logic [15:0]     fill_val;
  logic [15:0]     fill_val_next;
  logic [AW-1:0]   scnt;
  logic [AW-1:0]   scnt_next;
  logic            copy_valid;
  logic            copy_valid_next;
  logic [AW-1:0]   copy_addr;
  logic [AW-1:0]   copy_addr_next;

  logic [15:0]     mem [CELL_COUNT];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     rd_data;

  logic            last_row;
  logic [AW-1:0]   cur_addr;
  logic            load_out;
  logic [LW-1:0]   linear;

  assign last_row = (row_q == RW'(ROWS - 1));
  assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign linear   = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
  assign load_out = (state == ST_RESULT) && (!out_valid || out_ready);
  // The head is popped exactly when its result is about to be produced.
  assign op_pop   = (state_next == ST_RESULT) && (state != ST_RESULT);

  always_comb begin
    state_next      = state;
    col_next        = col_q;
    row_next        = row_q;
    resume_next     = resume;
    res_read_next   = res_read;
    fill_addr_next  = fill_addr;
    fill_val_next   = fill_val;
    scnt_next       = scnt;
    copy_valid_next = 1'b0;
    copy_addr_next  = scnt;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = fill_val;
        if (fill_addr == AW'(CELL_COUNT - 1)) begin
          state_next = resume ? ST_IDLE : ST_RESULT;
        end else begin
          fill_addr_next = fill_addr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (op_valid) begin
          res_read_next = (op.kind == KIND_READ);
          case (op.kind)
            KIND_PUT: begin
              if (col_q >= CW'(COLUMNS)) begin
                // Wrap to a new line, then look at the same word again.
                col_next = '0;
                if (last_row) begin
                  scnt_next   = '0;
                  resume_next = 1'b1;
                  state_next  = ST_SCROLL;
                end else begin
                  row_next = row_q + 1'b1;
                end
              end else begin
                case (op.cls)
                  CH_LF: begin
                    col_next = '0;
                    if (last_row) begin
                      scnt_next   = '0;
                      resume_next = 1'b0;
                      state_next  = ST_SCROLL;
                    end else begin
                      row_next   = row_q + 1'b1;
                      state_next = ST_RESULT;
                    end
                  end
                  CH_CR: begin
                    col_next   = '0;
                    state_next = ST_RESULT;
                  end
                  CH_TAB: begin
                    col_next   = col_q + CW'(TAB_ADVANCE);
                    state_next = ST_RESULT;
                  end
                  CH_BS: begin
                    if (8'(col_q) > {1'b0, cfg.bs_min}) begin
                      col_next  = col_q - 1'b1;
                      mem_we    = 1'b1;
                      mem_waddr = cur_addr - 1'b1;
                      mem_wdata = {cfg.attr, CHAR_SPACE};
                    end
                    state_next = ST_RESULT;
                  end
                  default: begin
                    mem_we     = 1'b1;
                    mem_waddr  = cur_addr;
                    mem_wdata  = {cfg.attr, op.code};
                    col_next   = col_q + 1'b1;
                    state_next = ST_RESULT;
                  end
                endcase
              end
            end
            KIND_CLEAR: begin
              fill_addr_next = '0;
              fill_val_next  = {cfg.attr, CHAR_SPACE};
              resume_next    = 1'b0;
              state_next     = ST_FILL;
            end
            KIND_SET: begin
              col_next   = CW'(op.col);
              row_next   = RW'(op.row);
              state_next = ST_RESULT;
            end
            default: begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(op.row) * AW'(COLUMNS) + AW'(op.col);
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Each copied word is read one row down and written in the following cycle.
        if (copy_valid) begin
          mem_we    = 1'b1;
          mem_waddr = copy_addr;
          mem_wdata = rd_data;
        end
        if (scnt != AW'(LAST_BASE)) begin
          mem_re          = 1'b1;
          mem_raddr       = scnt + AW'(COLUMNS);
          copy_valid_next = 1'b1;
          copy_addr_next  = scnt;
          scnt_next       = scnt + 1'b1;
        end else begin
          fill_addr_next = AW'(LAST_BASE);
          fill_val_next  = {cfg.attr, CHAR_NUL};
          state_next     = ST_FILL;
        end
      end

      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      col_q      <= '0;
      row_q      <= '0;
      resume     <= 1'b1;
      res_read   <= 1'b0;
      fill_addr  <= '0;
      fill_val   <= RESET_CELL;
      copy_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      col_q      <= col_next;
      row_q      <= row_next;
      resume     <= resume_next;
      res_read   <= res_read_next;
      fill_addr  <= fill_addr_next;
      fill_val   <= fill_val_next;
      copy_valid <= copy_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scnt      <= scnt_next;
    copy_addr <= copy_addr_next;
    if (load_out) begin
      cursor_col    <= 7'(col_q);
      cursor_row    <= 5'(row_q);
      cursor_linear <= 11'(linear);
      cell_value    <= res_read ? rd_data : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule
